FILE: design/atsd_pkg.sv
`default_nettype none

package atsd_pkg;

   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int AXES       = 3;
   localparam int ROOT_STEPS = 16;
   localparam int STEP_W     = $clog2(ROOT_STEPS);

   localparam logic [15:0] ONE_G     = 16'd4096;
   localparam logic [31:0] ROOT_BIT0 = 32'h4000_0000;

   localparam logic [14:0] RST_TILT_THRESHOLD   = 15'd2048;
   localparam logic [1:0]  RST_AXIS_INVERT      = 2'd0;
   localparam logic [15:0] RST_TAP_THRESHOLD    = 16'd6144;
   localparam logic [15:0] RST_TAP_DEBOUNCE     = 16'd200;
   localparam logic [15:0] RST_SHAKE_WINDOW     = 16'd1000;
   localparam logic [15:0] RST_SHAKE_PEAK_HIGH  = 16'd4096;
   localparam logic [15:0] RST_SHAKE_PEAK_LOW   = 16'd1024;
   localparam logic [3:0]  RST_SHAKE_PEAKS      = 4'd4;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_TILT_THRESHOLD     = 4'd0,
      CSR_AXIS_INVERT        = 4'd1,
      CSR_TAP_THRESHOLD      = 4'd2,
      CSR_TAP_DEBOUNCE_MS    = 4'd3,
      CSR_SHAKE_WINDOW_MS    = 4'd4,
      CSR_SHAKE_PEAK_HIGH    = 4'd5,
      CSR_SHAKE_PEAK_LOW     = 4'd6,
      CSR_SHAKE_PEAKS_NEEDED = 4'd7
   } csr_idx_type;

   typedef enum logic [2:0] {
      TILT_FLAT  = 3'd0,
      TILT_LEFT  = 3'd1,
      TILT_RIGHT = 3'd2,
      TILT_UP    = 3'd3,
      TILT_DOWN  = 3'd4
   } tilt_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SQUARE,
      ST_ROOT,
      ST_FINISH
   } state_type;

   typedef enum logic [1:0] {
      AXIS_X,
      AXIS_Y,
      AXIS_Z
   } axis_type;

   typedef struct packed {
      logic     load;
      logic     sq_en;
      axis_type sq_sel;
      logic     root_en;
      logic     commit;
   } cmd_type;

   typedef struct packed {
      logic clear_mode;
   } status_type;

endpackage

`default_nettype wire

FILE: design/atsd_if.sv
`default_nettype none

interface atsd_req_if ();
   logic               valid;
   logic               ready;
   logic               mode;
   logic signed [15:0] accel_x;
   logic signed [15:0] accel_y;
   logic signed [15:0] accel_z;
   logic [31:0]        time_ms;

   modport source (output valid, output mode, output accel_x, output accel_y,
                   output accel_z, output time_ms, input ready);
   modport sink (input valid, input mode, input accel_x, input accel_y,
                 input accel_z, input time_ms, output ready);
endinterface

interface atsd_rsp_if ();
   logic        valid;
   logic        ready;
   logic [15:0] dyn_accel;
   logic [2:0]  tilt;
   logic        tap;
   logic        shake;

   modport source (output valid, output dyn_accel, output tilt, output tap,
                   output shake, input ready);
   modport sink (input valid, input dyn_accel, input tilt, input tap,
                 input shake, output ready);
endinterface

interface atsd_csr_if import atsd_pkg::*; ();
   logic                  valid;
   logic                  ready;
   logic [CSR_IDX_W-1:0]  index;
   logic [CSR_DATA_W-1:0] data;

   modport source (output valid, output index, output data, input ready);
   modport sink (input valid, input index, input data, output ready);
endinterface

`default_nettype wire

FILE: design/accel_tilt_tap_shake_detector.sv
// Tilt, tap and shake detector for raw three-axis accelerometer samples.
// The req_bus channel carries one sample word: mode, accel_x/y/z and
// time_ms. The rsp_bus channel returns one result word per sample:
// dyn_accel, tilt, tap and shake. Both use valid/ready and a word moves
// when both are high at a rising clock edge.
// The csr_bus channel writes one configuration register per word; it is
// always ready and should only be used while the block is idle.
// A new sample is accepted only once the previous one is committed: the
// axes are squared and summed on one shared 16x16 multiplier, and the
// square root then produces one result bit per cycle, followed by a
// commit step that registers the result word.
// A clear-mode word skips the square and root steps and returns an all-zero result.
// The output register holds a finished result while the receiver stalls;
// the next sample is accepted and computed meanwhile, and it waits in its
// final cycle until the output register is free.
// Reset restores the register defaults, clears the tap and shake history,
// arms the peak detector and empties the output register.
`default_nettype none

module accel_tilt_tap_shake_detector import atsd_pkg::*; (
   input logic      clock,
   input logic      reset,
   atsd_req_if.sink   req_bus,
   atsd_rsp_if.source rsp_bus,
   atsd_csr_if.sink   csr_bus
);

   cmd_type    cmd;
   status_type status;

   assign csr_bus.ready = 1'b1;

   atsd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_bus.valid),
      .req_ready (req_bus.ready),
      .rsp_valid (rsp_bus.valid),
      .rsp_ready (rsp_bus.ready),
      .status    (status),
      .cmd       (cmd)
   );

   atsd_dp u_dp (
      .clock         (clock),
      .reset         (reset),
      .cmd           (cmd),
      .status        (status),
      .req_mode      (req_bus.mode),
      .req_accel_x   (req_bus.accel_x),
      .req_accel_y   (req_bus.accel_y),
      .req_accel_z   (req_bus.accel_z),
      .req_time_ms   (req_bus.time_ms),
      .csr_write     (csr_bus.valid && csr_bus.ready),
      .csr_index     (csr_bus.index),
      .csr_data      (csr_bus.data),
      .rsp_dyn_accel (rsp_bus.dyn_accel),
      .rsp_tilt      (rsp_bus.tilt),
      .rsp_tap       (rsp_bus.tap),
      .rsp_shake     (rsp_bus.shake)
   );

   a_commit_slot_free: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |-> (!rsp_bus.valid || rsp_bus.ready))
      else $error("result committed over a pending word");

   a_commit_shows_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.commit |=> rsp_bus.valid)
      else $error("committed result not presented");

   a_no_early_commit: assert property (@(posedge clock) disable iff (reset)
      (req_bus.valid && req_bus.ready) |=> !cmd.commit)
      else $error("commit in the cycle after acceptance");

   a_single_op: assert property (@(posedge clock) disable iff (reset)
      !(cmd.sq_en && cmd.root_en) && !(cmd.load && cmd.commit))
      else $error("conflicting datapath commands");

endmodule

`default_nettype wire

FILE: design/atsd_ctrl.sv
`default_nettype none

module atsd_ctrl import atsd_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] cnt_ff, cnt_in;
   logic              rsp_valid_ff, rsp_valid_in;
   logic              slot_free;

   assign slot_free = !rsp_valid_ff || rsp_ready;

   always_comb begin
      state_in = state_ff;
      cnt_in   = cnt_ff;
      case (state_ff)
         ST_IDLE: begin
            cnt_in = '0;
            if (req_valid) begin
               state_in = ST_SQUARE;
            end
         end
         ST_SQUARE: begin
            if (status.clear_mode) begin
               state_in = ST_FINISH;
            end else if (cnt_ff == STEP_W'(AXES - 1)) begin
               state_in = ST_ROOT;
               cnt_in   = '0;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_ROOT: begin
            if (cnt_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = ST_FINISH;
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         ST_FINISH: begin
            if (slot_free) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      req_ready   = 1'b0;
      cmd         = '0;
      cmd.sq_sel  = axis_type'(cnt_ff[1:0]);
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            cmd.load  = req_valid;
         end
         ST_SQUARE: begin
            cmd.sq_en = !status.clear_mode;
         end
         ST_ROOT: begin
            cmd.root_en = 1'b1;
         end
         ST_FINISH: begin
            cmd.commit = slot_free;
         end
         default: begin
            req_ready = 1'b0;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = cmd.commit || (rsp_valid_ff && !rsp_ready);
   end

   assign rsp_valid = rsp_valid_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

`default_nettype wire

FILE: design/atsd_dp.sv
`default_nettype none

module atsd_dp import atsd_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  cmd_type               cmd,
   output status_type            status,
   input  logic                  req_mode,
   input  logic signed [15:0]    req_accel_x,
   input  logic signed [15:0]    req_accel_y,
   input  logic signed [15:0]    req_accel_z,
   input  logic [31:0]           req_time_ms,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output logic [15:0]           rsp_dyn_accel,
   output logic [2:0]            rsp_tilt,
   output logic                  rsp_tap,
   output logic                  rsp_shake
);

   logic [14:0] tilt_thr_ff, tilt_thr_in;
   logic [1:0]  axis_inv_ff, axis_inv_in;
   logic [15:0] tap_thr_ff, tap_thr_in;
   logic [15:0] tap_deb_ff, tap_deb_in;
   logic [15:0] win_ff, win_in;
   logic [15:0] peak_high_ff, peak_high_in;
   logic [15:0] peak_low_ff, peak_low_in;
   logic [3:0]  peaks_needed_ff, peaks_needed_in;

   logic               mode_ff, mode_in;
   logic signed [15:0] x_ff, x_in;
   logic signed [15:0] y_ff, y_in;
   logic signed [15:0] z_ff, z_in;
   logic [31:0]        time_ff, time_in;

   logic [31:0] rem_ff, rem_in;
   logic [31:0] root_ff, root_in;
   logic [31:0] bit_ff, bit_in;

   logic [31:0] last_tap_ff, last_tap_in;
   logic [31:0] first_peak_ff, first_peak_in;
   logic [3:0]  peak_count_ff, peak_count_in;
   logic        armed_ff, armed_in;

   logic [15:0] dyn_out_ff, dyn_out_in;
   tilt_type    tilt_out_ff, tilt_out_in;
   logic        tap_out_ff, tap_out_in;
   logic        shake_out_ff, shake_out_in;

   logic signed [15:0] sq_op;
   logic signed [31:0] sq_prod;
   logic [31:0]        trial;

   logic [15:0] mag;
   logic [15:0] dyn;

   logic signed [17:0] xs, ys, zs, ax, ay, az, thr_s, flat_lim;
   tilt_type           tilt_val;

   logic [31:0] since_tap, since_peak;
   logic        tap_hit, peak_hit, rearm, shake_hit;
   logic [3:0]  pc0, pc1;

   always_comb begin
      tilt_thr_in     = tilt_thr_ff;
      axis_inv_in     = axis_inv_ff;
      tap_thr_in      = tap_thr_ff;
      tap_deb_in      = tap_deb_ff;
      win_in          = win_ff;
      peak_high_in    = peak_high_ff;
      peak_low_in     = peak_low_ff;
      peaks_needed_in = peaks_needed_ff;
      if (csr_write) begin
         case (csr_index)
            CSR_TILT_THRESHOLD:     tilt_thr_in     = csr_data[14:0];
            CSR_AXIS_INVERT:        axis_inv_in     = csr_data[1:0];
            CSR_TAP_THRESHOLD:      tap_thr_in      = csr_data;
            CSR_TAP_DEBOUNCE_MS:    tap_deb_in      = csr_data;
            CSR_SHAKE_WINDOW_MS:    win_in          = csr_data;
            CSR_SHAKE_PEAK_HIGH:    peak_high_in    = csr_data;
            CSR_SHAKE_PEAK_LOW:     peak_low_in     = csr_data;
            CSR_SHAKE_PEAKS_NEEDED: peaks_needed_in = csr_data[3:0];
            default: begin
               tilt_thr_in = tilt_thr_ff;
            end
         endcase
      end
   end

   always_comb begin
      mode_in = cmd.load ? req_mode    : mode_ff;
      x_in    = cmd.load ? req_accel_x : x_ff;
      y_in    = cmd.load ? req_accel_y : y_ff;
      z_in    = cmd.load ? req_accel_z : z_ff;
      time_in = cmd.load ? req_time_ms : time_ff;
   end

   always_comb begin
      case (cmd.sq_sel)
         AXIS_X:  sq_op = x_ff;
         AXIS_Y:  sq_op = y_ff;
         AXIS_Z:  sq_op = z_ff;
         default: sq_op = z_ff;
      endcase
   end

   assign sq_prod = sq_op * sq_op;
   assign trial   = root_ff + bit_ff;

   always_comb begin
      rem_in  = rem_ff;
      root_in = root_ff;
      bit_in  = bit_ff;
      if (cmd.load) begin
         rem_in  = '0;
         root_in = '0;
         bit_in  = ROOT_BIT0;
      end else if (cmd.sq_en) begin
         rem_in = rem_ff + $unsigned(sq_prod);
      end else if (cmd.root_en) begin
         if (rem_ff >= trial) begin
            rem_in  = rem_ff - trial;
            root_in = (root_ff >> 1) + bit_ff;
         end else begin
            root_in = root_ff >> 1;
         end
         bit_in = bit_ff >> 2;
      end
   end

   assign mag = root_ff[15:0];
   assign dyn = (mag >= ONE_G) ? (mag - ONE_G) : (ONE_G - mag);

   always_comb begin
      xs       = {{2{x_ff[15]}}, x_ff};
      ys       = {{2{y_ff[15]}}, y_ff};
      zs       = {{2{z_ff[15]}}, z_ff};
      thr_s    = {3'b000, tilt_thr_ff};
      flat_lim = $signed({2'b00, ONE_G}) - thr_s;
      if (axis_inv_ff[0]) begin
         xs = -xs;
      end
      if (axis_inv_ff[1]) begin
         ys = -ys;
      end
      ax = (xs < 0) ? -xs : xs;
      ay = (ys < 0) ? -ys : ys;
      az = (zs < 0) ? -zs : zs;
      tilt_val = TILT_FLAT;
      if (az > ax && az > ay && az > flat_lim) begin
         tilt_val = TILT_FLAT;
      end else if (ax >= ay) begin
         if (xs >= thr_s) begin
            tilt_val = TILT_RIGHT;
         end else if (xs <= -thr_s) begin
            tilt_val = TILT_LEFT;
         end
      end else begin
         if (ys >= thr_s) begin
            tilt_val = TILT_DOWN;
         end else if (ys <= -thr_s) begin
            tilt_val = TILT_UP;
         end
      end
   end

   always_comb begin
      since_tap  = time_ff - last_tap_ff;
      since_peak = time_ff - first_peak_ff;
      tap_hit    = (dyn >= tap_thr_ff) && (since_tap >= {16'b0, tap_deb_ff});
      if (peak_count_ff != 4'd0 && since_peak > {16'b0, win_ff}) begin
         pc0 = 4'd0;
      end else begin
         pc0 = peak_count_ff;
      end
      peak_hit  = armed_ff && (dyn >= peak_high_ff);
      rearm     = !armed_ff && (dyn <= peak_low_ff);
      pc1       = peak_hit ? (pc0 + 4'd1) : pc0;
      shake_hit = (pc1 >= peaks_needed_ff);
   end

   always_comb begin
      last_tap_in   = last_tap_ff;
      first_peak_in = first_peak_ff;
      peak_count_in = peak_count_ff;
      armed_in      = armed_ff;
      dyn_out_in    = dyn_out_ff;
      tilt_out_in   = tilt_out_ff;
      tap_out_in    = tap_out_ff;
      shake_out_in  = shake_out_ff;
      if (cmd.commit) begin
         if (mode_ff) begin
            peak_count_in = 4'd0;
            armed_in      = 1'b1;
            dyn_out_in    = '0;
            tilt_out_in   = TILT_FLAT;
            tap_out_in    = 1'b0;
            shake_out_in  = 1'b0;
         end else begin
            if (tap_hit) begin
               last_tap_in = time_ff;
            end
            if (peak_hit && pc0 == 4'd0) begin
               first_peak_in = time_ff;
            end
            peak_count_in = shake_hit ? 4'd0 : pc1;
            if (peak_hit) begin
               armed_in = 1'b0;
            end else if (rearm) begin
               armed_in = 1'b1;
            end
            dyn_out_in   = dyn;
            tilt_out_in  = tilt_val;
            tap_out_in   = tap_hit;
            shake_out_in = shake_hit;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tilt_thr_ff     <= RST_TILT_THRESHOLD;
         axis_inv_ff     <= RST_AXIS_INVERT;
         tap_thr_ff      <= RST_TAP_THRESHOLD;
         tap_deb_ff      <= RST_TAP_DEBOUNCE;
         win_ff          <= RST_SHAKE_WINDOW;
         peak_high_ff    <= RST_SHAKE_PEAK_HIGH;
         peak_low_ff     <= RST_SHAKE_PEAK_LOW;
         peaks_needed_ff <= RST_SHAKE_PEAKS;
         last_tap_ff     <= '0;
         first_peak_ff   <= '0;
         peak_count_ff   <= '0;
         armed_ff        <= 1'b1;
      end else begin
         tilt_thr_ff     <= tilt_thr_in;
         axis_inv_ff     <= axis_inv_in;
         tap_thr_ff      <= tap_thr_in;
         tap_deb_ff      <= tap_deb_in;
         win_ff          <= win_in;
         peak_high_ff    <= peak_high_in;
         peak_low_ff     <= peak_low_in;
         peaks_needed_ff <= peaks_needed_in;
         last_tap_ff     <= last_tap_in;
         first_peak_ff   <= first_peak_in;
         peak_count_ff   <= peak_count_in;
         armed_ff        <= armed_in;
      end
   end

   always_ff @(posedge clock) begin
      mode_ff      <= mode_in;
      x_ff         <= x_in;
      y_ff         <= y_in;
      z_ff         <= z_in;
      time_ff      <= time_in;
      rem_ff       <= rem_in;
      root_ff      <= root_in;
      bit_ff       <= bit_in;
      dyn_out_ff   <= dyn_out_in;
      tilt_out_ff  <= tilt_out_in;
      tap_out_ff   <= tap_out_in;
      shake_out_ff <= shake_out_in;
   end

   assign status.clear_mode = mode_ff;
   assign rsp_dyn_accel     = dyn_out_ff;
   assign rsp_tilt          = tilt_out_ff;
   assign rsp_tap           = tap_out_ff;
   assign rsp_shake         = shake_out_ff;

endmodule

`default_nettype wire

FILE: tb/tb.sv
`timescale 1ns / 100ps

module tb;
   import atsd_pkg::*;

   localparam int CLOCK_PERIOD = 20;
   localparam int RESET_CYCLES = 11;
   localparam int CYCLE_LIMIT  = 400000;
   localparam int MAX_REPORTS  = 10;
   localparam int DRAIN_CYCLES = 40;
   localparam int SWEEP_PHASES = 8;
   localparam int G_LSB        = ONE_G;

   localparam logic signed [15:0] CORNER_VALUES [8] = '{
      -16'sd32768, -16'sd32767, -16'sd4096, -16'sd1, 16'sd0, 16'sd1, 16'sd4096, 16'sd32767
   };

   typedef struct {
      logic               mode;
      logic signed [15:0] accel_x;
      logic signed [15:0] accel_y;
      logic signed [15:0] accel_z;
      logic [31:0]        time_ms;
   } sample_type;

   typedef struct {
      logic [15:0] dyn_accel;
      tilt_type    tilt;
      logic        tap;
      logic        shake;
   } detect_type;

   typedef enum int {
      SMP_QUIET,
      SMP_PEAK,
      SMP_FREEFALL,
      SMP_WILD,
      SMP_EXTREME,
      SMP_CLEAR
   } sample_kind_type;

   logic clock;
   logic reset;

   atsd_req_if req_bus ();
   atsd_rsp_if rsp_bus ();
   atsd_csr_if csr_bus ();

   accel_tilt_tap_shake_detector dut (
      .clock   (clock),
      .reset   (reset),
      .req_bus (req_bus),
      .rsp_bus (rsp_bus),
      .csr_bus (csr_bus)
   );

   logic [14:0] tilt_limit;
   logic [1:0]  invert_axes;
   logic [15:0] tap_level;
   logic [15:0] tap_holdoff;
   logic [15:0] shake_window;
   logic [15:0] peak_high;
   logic [15:0] peak_low;
   logic [3:0]  peaks_needed;

   logic [31:0] last_tap_ms;
   logic [31:0] first_peak_ms;
   logic [3:0]  peak_count;
   logic        peak_armed;

   detect_type expected_results[$];

   int mismatches   = 0;
   int samples_sent = 0;
   int clears_sent  = 0;
   int results_seen = 0;
   int taps_seen    = 0;
   int shakes_seen  = 0;
   int reg_writes   = 0;
   int cycle_count  = 0;
   int burst_left   = 0;
   bit gaps_on      = 1'b0;
   bit stalls_on    = 1'b0;
   logic [31:0] now_ms;

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count = cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d results outstanding", cycle_count,
                  expected_results.size());
         $display("end of test: mismatches");
         $finish;
      end
   end

   function automatic detect_type predict_detection(input sample_type s);
      detect_type  r;
      int          x, y, z, mx, my, mz, limit, root, dyn;
      longint      power, trial;
      logic [31:0] tap_gap, peak_gap;
      r.dyn_accel = '0;
      r.tilt = TILT_FLAT;
      r.tap = 1'b0;
      r.shake = 1'b0;
      if (s.mode) begin
         peak_count = '0;
         peak_armed = 1'b1;
         return r;
      end
      x = s.accel_x;
      y = s.accel_y;
      z = s.accel_z;
      power = longint'(x) * x + longint'(y) * y + longint'(z) * z;
      root = 0;
      for (int b = 15; b >= 0; b--) begin
         trial = root + (1 << b);
         if (trial * trial <= power) root = int'(trial);
      end
      dyn = (root >= G_LSB) ? root - G_LSB : G_LSB - root;
      r.dyn_accel = 16'(dyn);

      if (invert_axes[0]) x = -x;
      if (invert_axes[1]) y = -y;
      mx = (x < 0) ? -x : x;
      my = (y < 0) ? -y : y;
      mz = (z < 0) ? -z : z;
      limit = tilt_limit;
      if (mz > mx && mz > my && mz > G_LSB - limit) begin
         r.tilt = TILT_FLAT;
      end else if (mx >= my) begin
         if (x >= limit) r.tilt = TILT_RIGHT;
         else if (x <= -limit) r.tilt = TILT_LEFT;
      end else begin
         if (y >= limit) r.tilt = TILT_DOWN;
         else if (y <= -limit) r.tilt = TILT_UP;
      end

      tap_gap = s.time_ms - last_tap_ms;
      if (dyn >= int'(tap_level) && tap_gap >= {16'd0, tap_holdoff}) begin
         last_tap_ms = s.time_ms;
         r.tap = 1'b1;
      end

      peak_gap = s.time_ms - first_peak_ms;
      if (peak_count != 0 && peak_gap > {16'd0, shake_window}) peak_count = '0;
      if (peak_armed && dyn >= int'(peak_high)) begin
         if (peak_count == 0) first_peak_ms = s.time_ms;
         peak_count = peak_count + 4'd1;
         peak_armed = 1'b0;
      end else if (!peak_armed && dyn <= int'(peak_low)) begin
         peak_armed = 1'b1;
      end
      if (peak_count >= peaks_needed) begin
         peak_count = '0;
         r.shake = 1'b1;
      end
      return r;
   endfunction

   function automatic void apply_reg(input logic [CSR_IDX_W-1:0] idx,
                                     input logic [CSR_DATA_W-1:0] wdata);
      case (idx)
         CSR_TILT_THRESHOLD:     tilt_limit = wdata[14:0];
         CSR_AXIS_INVERT:        invert_axes = wdata[1:0];
         CSR_TAP_THRESHOLD:      tap_level = wdata;
         CSR_TAP_DEBOUNCE_MS:    tap_holdoff = wdata;
         CSR_SHAKE_WINDOW_MS:    shake_window = wdata;
         CSR_SHAKE_PEAK_HIGH:    peak_high = wdata;
         CSR_SHAKE_PEAK_LOW:     peak_low = wdata;
         CSR_SHAKE_PEAKS_NEEDED: peaks_needed = wdata[3:0];
         default: ;
      endcase
   endfunction

   function automatic logic signed [15:0] signed_axis(input int lo, input int hi);
      int v;
      v = $urandom_range(hi, lo);
      if ($urandom_range(1, 0) != 0) v = -v;
      return 16'(v);
   endfunction

   function automatic sample_type sample_at(input logic mode, input int x, input int y,
                                            input int z, input logic [31:0] t);
      sample_type s;
      s.mode = mode;
      s.accel_x = 16'(x);
      s.accel_y = 16'(y);
      s.accel_z = 16'(z);
      s.time_ms = t;
      return s;
   endfunction

   function automatic sample_type make_sample(input sample_kind_type kind);
      sample_type         s;
      logic signed [15:0] axes [3];
      int                 lead;
      lead = $urandom_range(2, 0);
      for (int i = 0; i < 3; i++) begin
         case (kind)
            SMP_QUIET:    axes[i] = (i == lead) ? signed_axis(3200, 4600) : signed_axis(0, 2600);
            SMP_PEAK:     axes[i] = (i == lead) ? signed_axis(9000, 32767) : signed_axis(0, 6000);
            SMP_FREEFALL: axes[i] = signed_axis(0, 400);
            SMP_EXTREME:  axes[i] = CORNER_VALUES[$urandom_range(7, 0)];
            default:      axes[i] = 16'($urandom);
         endcase
      end
      s = sample_at(kind == SMP_CLEAR, axes[0], axes[1], axes[2], now_ms);
      if (kind == SMP_CLEAR) s.time_ms = $urandom;
      return s;
   endfunction

   function automatic int shaped_value(input int lo, input int hi, input int typ_lo,
                                       input int typ_hi);
      int r;
      r = $urandom_range(9, 0);
      if (r == 0) return lo;
      if (r == 1) return hi;
      if (r == 2) return $urandom_range(hi, lo);
      return $urandom_range(typ_hi, typ_lo);
   endfunction

   task automatic advance_time(input int span);
      now_ms = now_ms + $urandom_range(span, 0);
   endtask

   task automatic send_sample(input sample_type s);
      int gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(12, 1);
         if (gaps_on) begin
            gap = $urandom_range(8, 1);
            @(negedge clock);
            req_bus.valid <= 1'b0;
            repeat (gap - 1) @(negedge clock);
         end
      end
      burst_left--;
      @(negedge clock);
      req_bus.valid <= 1'b1;
      req_bus.mode <= s.mode;
      req_bus.accel_x <= s.accel_x;
      req_bus.accel_y <= s.accel_y;
      req_bus.accel_z <= s.accel_z;
      req_bus.time_ms <= s.time_ms;
      do @(posedge clock); while (!req_bus.ready);
      expected_results.push_back(predict_detection(s));
      samples_sent++;
      if (s.mode) clears_sent++;
   endtask

   task automatic drain_results();
      @(negedge clock);
      req_bus.valid <= 1'b0;
      burst_left = 0;
      while (expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_reg(input logic [CSR_IDX_W-1:0] idx, input logic [CSR_DATA_W-1:0] wdata);
      @(negedge clock);
      csr_bus.valid <= 1'b1;
      csr_bus.index <= idx;
      csr_bus.data <= wdata;
      do @(posedge clock); while (!csr_bus.ready);
      apply_reg(idx, wdata);
      reg_writes++;
      @(negedge clock);
      csr_bus.valid <= 1'b0;
   endtask

   task automatic load_config(input int tilt_v, input int invert_v, input int tap_v,
                              input int holdoff_v, input int window_v, input int high_v,
                              input int low_v, input int needed_v);
      write_reg(CSR_TILT_THRESHOLD, {1'($urandom), 15'(tilt_v)});
      write_reg(CSR_AXIS_INVERT, {14'($urandom), 2'(invert_v)});
      write_reg(CSR_TAP_THRESHOLD, 16'(tap_v));
      write_reg(CSR_TAP_DEBOUNCE_MS, 16'(holdoff_v));
      write_reg(CSR_SHAKE_WINDOW_MS, 16'(window_v));
      write_reg(CSR_SHAKE_PEAK_HIGH, 16'(high_v));
      write_reg(CSR_SHAKE_PEAK_LOW, 16'(low_v));
      write_reg(CSR_SHAKE_PEAKS_NEEDED, {12'($urandom), 4'(needed_v)});
   endtask

   task automatic run_traffic(input int count);
      int stop_at, pick, peaks;
      stop_at = samples_sent + count;
      while (samples_sent < stop_at) begin
         pick = $urandom_range(99, 0);
         if (pick < 50) begin
            peaks = $urandom_range(int'(peaks_needed) + 2, 1);
            for (int k = 0; k < peaks; k++) begin
               advance_time(int'(shake_window) / 3 + 30);
               send_sample(make_sample(SMP_PEAK));
               repeat ($urandom_range(3, 1)) begin
                  advance_time(int'(shake_window) / 6 + 10);
                  send_sample(make_sample(SMP_QUIET));
               end
            end
         end else if (pick < 75) begin
            repeat ($urandom_range(6, 2)) begin
               advance_time(int'(tap_holdoff) + int'(tap_holdoff) / 2 + 20);
               send_sample(make_sample($urandom_range(3, 0) != 0 ? SMP_PEAK : SMP_QUIET));
            end
         end else if (pick < 92) begin
            advance_time(200);
            send_sample(make_sample(
               sample_kind_type'($urandom_range(SMP_EXTREME, SMP_FREEFALL))));
         end else if (pick < 97) begin
            send_sample(make_sample(SMP_CLEAR));
         end else begin
            now_ms = now_ms + $urandom;
            send_sample(make_sample(SMP_QUIET));
         end
      end
   endtask

   task automatic test_directed_corners();
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      send_sample(sample_at(1'b0, 0, 0, 0, 32'd0));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'd10));
      send_sample(sample_at(1'b0, G_LSB, 0, 0, 32'd20));
      send_sample(sample_at(1'b0, -G_LSB, 0, 0, 32'd30));
      send_sample(sample_at(1'b0, 0, G_LSB, 0, 32'd40));
      send_sample(sample_at(1'b0, 0, -G_LSB, 0, 32'd50));
      // Strong samples right after reset must not tap inside the debounce time.
      send_sample(sample_at(1'b0, 32767, 32767, 32767, 32'd60));
      send_sample(sample_at(1'b0, -32768, -32768, -32768, 32'd70));
      send_sample(sample_at(1'b1, 32767, -32768, -1, 32'hFFFF_FFFF));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'd100));
      send_sample(sample_at(1'b0, 20000, 0, 0, 32'd250));
      send_sample(sample_at(1'b0, 0, 20000, 0, 32'd300));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'd320));
      send_sample(sample_at(1'b0, 0, -20000, 0, 32'd400));
      send_sample(sample_at(1'b0, 0, 0, -G_LSB, 32'd420));
      send_sample(sample_at(1'b0, -20000, 0, 0, 32'd500));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'd520));
      send_sample(sample_at(1'b0, 0, 0, 20000, 32'd600));
      send_sample(sample_at(1'b0, 2048, 2048, 0, 32'd710));
      send_sample(sample_at(1'b0, -2048, -2048, 1000, 32'd720));
      send_sample(sample_at(1'b0, -2047, -2048, 1000, 32'd730));
      // A peak after the window has lapsed starts a new count.
      send_sample(sample_at(1'b0, 30000, 0, 0, 32'd2000));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'd2010));
      send_sample(sample_at(1'b0, 0, 30000, 0, 32'd3500));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'hFFFF_FF00));
      send_sample(sample_at(1'b0, 30000, 0, 0, 32'hFFFF_FF80));
      send_sample(sample_at(1'b0, 0, 0, G_LSB, 32'hFFFF_FFC0));
      send_sample(sample_at(1'b0, 0, -30000, 0, 32'd40));
      now_ms = 32'd40;
      drain_results();
   endtask

   task automatic test_register_extremes();
      // A zero tilt limit and both axes negated.
      load_config(0, 3, RST_TAP_THRESHOLD, RST_TAP_DEBOUNCE, RST_SHAKE_WINDOW,
                  RST_SHAKE_PEAK_HIGH, RST_SHAKE_PEAK_LOW, RST_SHAKE_PEAKS);
      gaps_on = 1'b1;
      stalls_on = 1'b0;
      run_traffic(25);
      drain_results();
      // With zero peaks needed every processed sample that is not a clear word reports a shake.
      load_config(32767, 1, 0, 0, 0, 0, 0, 0);
      gaps_on = 1'b0;
      stalls_on = 1'b1;
      run_traffic(25);
      drain_results();
      load_config(1, 2, 65535, 65535, 65535, 65535, 65535, 15);
      gaps_on = 1'b1;
      run_traffic(25);
      drain_results();
      // Writes beyond the register list leave every setting alone.
      for (int k = 0; k < 8; k++)
         write_reg(CSR_IDX_W'(CSR_SHAKE_PEAKS_NEEDED + 1 + k), 16'($urandom));
      run_traffic(20);
      drain_results();
      load_config(RST_TILT_THRESHOLD, RST_AXIS_INVERT, RST_TAP_THRESHOLD, 0, 65535, 3000,
                  2000, 1);
      gaps_on = 1'b0;
      stalls_on = 1'b0;
      run_traffic(25);
      drain_results();
   endtask

   task automatic test_register_sweep();
      for (int p = 0; p < SWEEP_PHASES; p++) begin
         load_config(shaped_value(0, 32767, 500, 4000), $urandom_range(3, 0),
                     shaped_value(0, 65535, 3000, 12000), shaped_value(0, 65535, 20, 400),
                     shaped_value(0, 65535, 150, 2500), shaped_value(0, 65535, 2500, 9000),
                     shaped_value(0, 65535, 200, 2000), shaped_value(0, 15, 1, 6));
         if ($urandom_range(1, 0) != 0)
            write_reg(CSR_IDX_W'(CSR_SHAKE_PEAKS_NEEDED + 1 + $urandom_range(7, 0)),
                      16'($urandom));
         if (p == 2) now_ms = 32'hFFFF_0000;
         gaps_on = 1'($urandom_range(1, 0));
         stalls_on = 1'($urandom_range(1, 0));
         run_traffic(150);
         drain_results();
      end
   endtask

   initial begin
      logic [15:0] stall_pattern;
      int          pattern_age;
      rsp_bus.ready = 1'b0;
      stall_pattern = 16'hFFFF;
      pattern_age = 0;
      forever begin
         @(negedge clock);
         if (pattern_age == 0) begin
            stall_pattern = 16'($urandom) | 16'h0001;
            pattern_age = $urandom_range(96, 16);
         end
         pattern_age--;
         rsp_bus.ready <= stalls_on ? stall_pattern[0] : 1'b1;
         stall_pattern = {stall_pattern[0], stall_pattern[15:1]};
      end
   end

   always @(posedge clock) begin
      detect_type want;
      if (!reset && rsp_bus.valid && rsp_bus.ready) begin
         results_seen++;
         if (rsp_bus.tap) taps_seen++;
         if (rsp_bus.shake) shakes_seen++;
         if (expected_results.size() == 0) begin
            mismatches++;
            if (mismatches <= MAX_REPORTS)
               $display("unexpected result word: dyn_accel %0d tilt %0d tap %0b shake %0b",
                        rsp_bus.dyn_accel, rsp_bus.tilt, rsp_bus.tap, rsp_bus.shake);
         end else begin
            want = expected_results.pop_front();
            if (rsp_bus.dyn_accel !== want.dyn_accel || rsp_bus.tilt !== want.tilt ||
                rsp_bus.tap !== want.tap || rsp_bus.shake !== want.shake) begin
               mismatches++;
               if (mismatches <= MAX_REPORTS)
                  $display({"result %0d mismatch: expected dyn_accel %0d tilt %0d tap %0b ",
                            "shake %0b, got dyn_accel %0d tilt %0d tap %0b shake %0b"},
                           results_seen, want.dyn_accel, want.tilt, want.tap, want.shake,
                           rsp_bus.dyn_accel, rsp_bus.tilt, rsp_bus.tap, rsp_bus.shake);
            end
         end
      end
   end

   initial begin
      reset = 1'b1;
      req_bus.valid = 1'b0;
      req_bus.mode = 1'b0;
      req_bus.accel_x = '0;
      req_bus.accel_y = '0;
      req_bus.accel_z = '0;
      req_bus.time_ms = '0;
      csr_bus.valid = 1'b0;
      csr_bus.index = '0;
      csr_bus.data = '0;
      now_ms = '0;
      tilt_limit = RST_TILT_THRESHOLD;
      invert_axes = RST_AXIS_INVERT;
      tap_level = RST_TAP_THRESHOLD;
      tap_holdoff = RST_TAP_DEBOUNCE;
      shake_window = RST_SHAKE_WINDOW;
      peak_high = RST_SHAKE_PEAK_HIGH;
      peak_low = RST_SHAKE_PEAK_LOW;
      peaks_needed = RST_SHAKE_PEAKS;
      last_tap_ms = '0;
      first_peak_ms = '0;
      peak_count = '0;
      peak_armed = 1'b1;
      repeat (RESET_CYCLES) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      test_directed_corners();
      test_register_extremes();
      test_register_sweep();

      drain_results();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (expected_results.size() != 0) begin
         mismatches += expected_results.size();
         $display("%0d expected results never arrived", expected_results.size());
      end
      $display("covered %0d samples (%0d clear words) and %0d register writes in %0d cycles",
               samples_sent, clears_sent, reg_writes, cycle_count);
      $display("checked %0d result words, %0d with a tap and %0d with a shake, %0d mismatches",
               results_seen, taps_seen, shakes_seen, mismatches);
      if (mismatches == 0) begin
         $display("end of test: clean");
      end else begin
         $display("end of test: mismatches");
      end
      $finish;
   end

endmodule
